>>> hw/rtl/rthsv_pkg.sv
// Shared types, constants and the divider step for the RGB to HSV pipeline.
// Used by every module under hw/rtl; has no dependencies of its own.
package rthsv_pkg;

    localparam int ChanW   = 8;
    localparam int HueW    = 15;
    localparam int SatW    = 16;
    localparam int NumW    = ChanW + SatW;          // dividend width
    localparam int QuotW   = SatW;                  // quotient bits per division
    localparam int DivSteps  = 4;                   // quotient bits per stage
    localparam int DivStages = QuotW / DivSteps;

    // Hue in 1/64 degree
    localparam logic [HueW-1:0] HueOff120 = 15'd7680;
    localparam logic [HueW-1:0] HueOff240 = 15'd15360;
    localparam logic [HueW-1:0] HueFull   = 15'd23040;

    // Sector that the largest channel selects
    localparam logic [1:0] SecRed   = 2'd0;
    localparam logic [1:0] SecGreen = 2'd1;
    localparam logic [1:0] SecBlue  = 2'd2;

    // One restoring-division lane: rq holds unused dividend bits on top and
    // finished quotient bits below them
    typedef struct packed {
        logic [ChanW-1:0] rem;
        logic [QuotW-1:0] rq;
        logic [ChanW-1:0] den;
    } div_lane_t;

    typedef struct packed {
        div_lane_t  hue;    // 3840 * |diff| / delta
        div_lane_t  sat;    // delta * 65535 / max, den carries max
        logic [1:0] sector;
        logic       neg;
        logic       gray;
    } div_item_t;

    function automatic div_lane_t div_step(input div_lane_t lane);
        logic [ChanW:0] trial;
        div_lane_t      res;
        trial = {lane.rem, lane.rq[QuotW-1]};
        res   = lane;
        if (trial >= {1'b0, lane.den})
        begin
            res.rem = ChanW'(trial - {1'b0, lane.den});
            res.rq  = {lane.rq[QuotW-2:0], 1'b1};
        end
        else
        begin
            res.rem = trial[ChanW-1:0];
            res.rq  = {lane.rq[QuotW-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage

>>> hw/rtl/rthsv_front.sv
// First pipeline stage: max, min, delta, hue sector and both dividends.
// Depends on rthsv_pkg.
module rthsv_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [rthsv_pkg::ChanW-1:0]  red_in,
    input  logic [rthsv_pkg::ChanW-1:0]  green_in,
    input  logic [rthsv_pkg::ChanW-1:0]  blue_in,
    output logic                         out_valid,
    input  logic                         out_ready,
    output rthsv_pkg::div_item_t         out_data
);

    logic                        valid_reg;
    rthsv_pkg::div_item_t        data_reg;
    rthsv_pkg::div_item_t        data_next;
    logic [rthsv_pkg::ChanW-1:0] mx;
    logic [rthsv_pkg::ChanW-1:0] mn;
    logic [rthsv_pkg::ChanW-1:0] delta;
    logic [rthsv_pkg::ChanW-1:0] lead;
    logic [rthsv_pkg::ChanW-1:0] trail;
    logic [rthsv_pkg::ChanW-1:0] abs_diff;
    logic [1:0]                  sector;
    logic [rthsv_pkg::NumW-1:0]  hue_num;
    logic [rthsv_pkg::NumW-1:0]  sat_num;

    always_comb
    begin
        mx = red_in;
        if (green_in > mx) mx = green_in;
        if (blue_in > mx) mx = blue_in;
        mn = red_in;
        if (green_in < mn) mn = green_in;
        if (blue_in < mn) mn = blue_in;
        delta = mx - mn;

        // ties on the largest channel go red, then green, then blue
        if (mx == red_in)
        begin
            sector = rthsv_pkg::SecRed;
            lead   = green_in;
            trail  = blue_in;
        end
        else if (mx == green_in)
        begin
            sector = rthsv_pkg::SecGreen;
            lead   = blue_in;
            trail  = red_in;
        end
        else
        begin
            sector = rthsv_pkg::SecBlue;
            lead   = red_in;
            trail  = green_in;
        end
        abs_diff = (lead < trail) ? (trail - lead) : (lead - trail);

        // 3840 * |diff| and delta * 65535 as shift and subtract
        hue_num = {4'd0, abs_diff, 12'd0} - {8'd0, abs_diff, 8'd0};
        sat_num = {delta, 16'd0} - {16'd0, delta};

        data_next.hue.rem = hue_num[rthsv_pkg::NumW-1 -: rthsv_pkg::ChanW];
        data_next.hue.rq  = hue_num[rthsv_pkg::QuotW-1:0];
        data_next.hue.den = delta;
        data_next.sat.rem = sat_num[rthsv_pkg::NumW-1 -: rthsv_pkg::ChanW];
        data_next.sat.rq  = sat_num[rthsv_pkg::QuotW-1:0];
        data_next.sat.den = mx;
        data_next.sector  = sector;
        data_next.neg     = (lead < trail);
        data_next.gray    = (delta == '0);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> hw/rtl/rthsv_div_stage.sv
// One divider stage: a few restoring-division steps on the hue and the
// saturation lanes. Depends on rthsv_pkg.
module rthsv_div_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rthsv_pkg::div_item_t in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rthsv_pkg::div_item_t out_data
);

    logic                 valid_reg;
    rthsv_pkg::div_item_t data_reg;
    rthsv_pkg::div_item_t data_next;

    always_comb
    begin
        data_next = in_data;
        for (int i = 0; i < rthsv_pkg::DivSteps; i++)
        begin
            data_next.hue = rthsv_pkg::div_step(data_next.hue);
            data_next.sat = rthsv_pkg::div_step(data_next.sat);
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> hw/rtl/rthsv_finish.sv
// Last stage: places the hue quotient in its sector, wraps negative red hue,
// zeroes hue and saturation of gray pixels and holds the output register. Depends on rthsv_pkg.
module rthsv_finish (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  rthsv_pkg::div_item_t         in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [rthsv_pkg::HueW-1:0]   hue_out,
    output logic [rthsv_pkg::SatW-1:0]   sat_out,
    output logic [rthsv_pkg::ChanW-1:0]  val_out
);

    logic                        valid_reg;
    logic [rthsv_pkg::HueW-1:0]  hue_reg;
    logic [rthsv_pkg::SatW-1:0]  sat_reg;
    logic [rthsv_pkg::ChanW-1:0] val_reg;
    logic [rthsv_pkg::HueW-1:0]  hue_next;
    logic [rthsv_pkg::HueW-1:0]  quot;
    logic [rthsv_pkg::HueW-1:0]  offset;
    logic                        rem_nz;

    always_comb
    begin
        // quotient never exceeds 3840
        quot   = in_data.hue.rq[rthsv_pkg::HueW-1:0];
        rem_nz = (in_data.hue.rem != '0);
        case (in_data.sector)
            rthsv_pkg::SecGreen: offset = rthsv_pkg::HueOff120;
            rthsv_pkg::SecBlue:  offset = rthsv_pkg::HueOff240;
            default:             offset = '0;
        endcase

        if (in_data.gray)
        begin
            hue_next = '0;
        end
        else if (in_data.sector == rthsv_pkg::SecRed)
        begin
            // truncation toward zero, then wrap below zero by a full turn
            if (in_data.neg && (quot != '0))
                hue_next = rthsv_pkg::HueFull - quot;
            else
                hue_next = quot;
        end
        else if (in_data.neg)
        begin
            // sum stays positive, so truncation rounds the fraction up here
            hue_next = offset - quot - {{(rthsv_pkg::HueW-1){1'b0}}, rem_nz};
        end
        else
        begin
            hue_next = offset + quot;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            hue_reg <= hue_next;
            sat_reg <= in_data.gray ? '0 : in_data.sat.rq;
            val_reg <= in_data.sat.den;
        end
    end

    assign out_valid = valid_reg;
    assign hue_out   = hue_reg;
    assign sat_out   = sat_reg;
    assign val_out   = val_reg;

endmodule

>>> hw/rtl/rgb_to_hsv_convert.sv
// RGB to HSV converter, top level: front stage, divider stages, finish stage.
// Depends on rthsv_pkg, rthsv_front, rthsv_div_stage and rthsv_finish.
//
// Usage:
//   Input channel in_valid/in_ready carries one pixel (red_in, green_in,
//   blue_in, 8 bits each). Output channel out_valid/out_ready carries
//   hue_out (1/64 degree, 0..23039), sat_out (delta/max * 65535, truncated)
//   and val_out (largest channel byte). A transfer happens when valid and
//   ready are both high.
//   Six register stages: one front stage, four divider stages of four
//   quotient bits each, one finish stage. out_valid rises once a pixel has
//   passed the front and divider registers into the finish register.
//   The two 16-bit divisions (hue by delta, saturation by max) set the depth.
//   Throughput is one pixel per cycle unless out_ready stalls the pipeline.
//   Every stage has its own valid bit and takes a new pixel whenever it is
//   empty or its successor takes its pixel, so a stalled receiver holds the
//   result in the output register while bubbles further up still fill.
//   Reset clears all valid bits; no pixel is in flight afterward.
module rgb_to_hsv_convert (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [rthsv_pkg::ChanW-1:0]  red_in,
    input  logic [rthsv_pkg::ChanW-1:0]  green_in,
    input  logic [rthsv_pkg::ChanW-1:0]  blue_in,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [rthsv_pkg::HueW-1:0]   hue_out,
    output logic [rthsv_pkg::SatW-1:0]   sat_out,
    output logic [rthsv_pkg::ChanW-1:0]  val_out
);

    rthsv_pkg::div_item_t stg_data  [0:rthsv_pkg::DivStages];
    logic                 stg_valid [0:rthsv_pkg::DivStages];
    logic                 stg_ready [0:rthsv_pkg::DivStages];

    rthsv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .out_valid (stg_valid[0]),
        .out_ready (stg_ready[0]),
        .out_data  (stg_data[0])
    );

    for (genvar s = 0; s < rthsv_pkg::DivStages; s++)
    begin : g_div
        rthsv_div_stage u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[s]),
            .in_ready  (stg_ready[s]),
            .in_data   (stg_data[s]),
            .out_valid (stg_valid[s+1]),
            .out_ready (stg_ready[s+1]),
            .out_data  (stg_data[s+1])
        );
    end

    rthsv_finish u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stg_valid[rthsv_pkg::DivStages]),
        .in_ready  (stg_ready[rthsv_pkg::DivStages]),
        .in_data   (stg_data[rthsv_pkg::DivStages]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .hue_out   (hue_out),
        .sat_out   (sat_out),
        .val_out   (val_out)
    );

endmodule

>>> hw/rtl/rthsv_checker.sv
// Port-level checks for rgb_to_hsv_convert, attached by bind.
// Depends on rthsv_pkg.
module rthsv_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [rthsv_pkg::HueW-1:0]   hue_out,
    input logic [rthsv_pkg::SatW-1:0]   sat_out,
    input logic [rthsv_pkg::ChanW-1:0]  val_out
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hue_out)
            && $stable(sat_out) && $stable(val_out))
        else $error("output changed while stalled");

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> hue_out < rthsv_pkg::HueFull)
        else $error("hue beyond full turn");

    // zero saturation only for gray, and gray has zero hue
    a_gray_hue: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sat_out == '0 |-> hue_out == '0)
        else $error("gray pixel with nonzero hue");

    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && val_out == '0 |-> hue_out == '0 && sat_out == '0)
        else $error("black pixel with nonzero hue or saturation");

    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result present right after reset");

endmodule

bind rgb_to_hsv_convert rthsv_checker u_checker (.*);
